/* hdl/tgl_pkg.sv */
// Shared types, character codes and glyph tables for the text glyph layout block.
`default_nettype none

package tgl_pkg;

    // Character codes with a meaning of their own
    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_NL    = 8'h0A;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_FIRST = 8'h21;  // '!'
    localparam logic [7:0] CHAR_LAST  = 8'h7E;  // '~'

    // Upper bounds of the strip ranges and the gap removed above each
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;  // 'z'
    localparam logic [7:0] CHAR_CARET   = 8'h5E;  // '^'
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;  // 'Z'
    localparam logic [7:0] CHAR_QUEST   = 8'h3F;  // '?'
    localparam logic [7:0] CHAR_SEMI    = 8'h3B;  // ';'
    localparam logic [7:0] GAP_ABOVE_LOWER_Z = 8'(3 + 2 + 3 + 1 + 3);
    localparam logic [7:0] GAP_ABOVE_CARET   = 8'(2 + 3 + 1 + 3);
    localparam logic [7:0] GAP_ABOVE_UPPER_Z = 8'(3 + 1 + 3);
    localparam logic [7:0] GAP_ABOVE_QUEST   = 8'(1 + 3);
    localparam logic [7:0] GAP_ABOVE_SEMI    = 8'd3;

    // Glyph column of 'j', whose S coordinate gets a one-unit nudge
    localparam logic [6:0] J_COL = 7'(512 / 8);

    // Pen geometry
    localparam int          PEN_W     = 12;
    localparam logic [11:0] PEN_MAX   = 12'hFFF;
    localparam logic [3:0]  LINE_STEP = 4'd12;
    localparam logic [3:0]  GLYPH_W   = 4'd8;
    localparam logic [4:0]  TAB_STOP  = 5'd16;

    // Register indexes of the configuration port
    localparam logic REG_ORIGIN_X = 1'b0;
    localparam logic REG_ORIGIN_Y = 1'b1;

    // Queue between front and back
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // Pen advance per character, space first
    localparam int ADV_ENTRIES = 95;
    localparam logic [2:0] ADVANCE_TAB [0:ADV_ENTRIES-1] = '{
        3'd2, 3'd4, 3'd5, 3'd0, 3'd0, 3'd7, 3'd7, 3'd2,
        3'd5, 3'd5, 3'd0, 3'd7, 3'd3, 3'd7, 3'd3, 3'd7,
        3'd7, 3'd7, 3'd7, 3'd7, 3'd7, 3'd7, 3'd7, 3'd7,
        3'd7, 3'd7, 3'd3, 3'd3, 3'd0, 3'd0, 3'd0, 3'd7,
        3'd0, 3'd7, 3'd7, 3'd7, 3'd7, 3'd7, 3'd7, 3'd7,
        3'd7, 3'd6, 3'd7, 3'd7, 3'd7, 3'd7, 3'd7, 3'd7,
        3'd7, 3'd7, 3'd7, 3'd7, 3'd7, 3'd7, 3'd7, 3'd7,
        3'd7, 3'd7, 3'd7, 3'd0, 3'd0, 3'd0, 3'd6, 3'd0,
        3'd0, 3'd6, 3'd6, 3'd6, 3'd6, 3'd6, 3'd6, 3'd6,
        3'd6, 3'd2, 3'd6, 3'd5, 3'd3, 3'd6, 3'd6, 3'd6,
        3'd6, 3'd6, 3'd6, 3'd6, 3'd6, 3'd6, 3'd6, 3'd6,
        3'd6, 3'd6, 3'd6, 3'd0, 3'd0, 3'd0, 3'd7
    };

    // What the back end does with one queued character
    typedef enum logic [1:0] {
        KIND_NUL,   // return pen to origin
        KIND_NL,    // carriage return and line feed
        KIND_TAB,   // jump to next tab stop
        KIND_ADV    // printable or space: advance, maybe draw
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic        emit;    // draw a glyph rectangle
        logic [2:0]  adv;     // pen advance in pixels
        logic [14:0] tex_s;   // strip S coordinate, U10.5
    } op_t;

    // Advance for a code from space to '~'
    function automatic logic [2:0] advance_of(input logic [7:0] c);
        logic [6:0] idx;
        idx = 7'(c - CHAR_SPACE);
        return ADVANCE_TAB[idx];
    endfunction

    // Strip S coordinate for a code from '!' to '~'
    function automatic logic [14:0] glyph_tex_s(input logic [7:0] c);
        logic [7:0] gap;
        logic [6:0] col;
        if (c > CHAR_LOWER_Z)
            gap = GAP_ABOVE_LOWER_Z;
        else if (c > CHAR_CARET)
            gap = GAP_ABOVE_CARET;
        else if (c > CHAR_UPPER_Z)
            gap = GAP_ABOVE_UPPER_Z;
        else if (c > CHAR_QUEST)
            gap = GAP_ABOVE_QUEST;
        else if (c > CHAR_SEMI)
            gap = GAP_ABOVE_SEMI;
        else
            gap = 8'd0;
        col = 7'(c - gap - CHAR_FIRST);
        return {col, 8'd0} + 15'(col == J_COL);
    endfunction

endpackage

`default_nettype wire

/* hdl/tgl_front.sv */
// Front end: accepts character beats, classifies them and queues the work.
`default_nettype none

module tgl_front (
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [7:0]    s_tdata,    // [7:0] char_code
    input  wire logic          q_full,
    output logic               q_push,
    output tgl_pkg::op_t       q_op
);
    import tgl_pkg::*;

    logic keep;

    // Classify the code; ignored codes are taken but never queued
    always_comb
    begin
        keep       = 1'b1;
        q_op.kind  = KIND_ADV;
        q_op.emit  = 1'b0;
        q_op.adv   = 3'd0;
        q_op.tex_s = 15'd0;
        if (s_tdata == CHAR_NUL)
        begin
            q_op.kind = KIND_NUL;
        end
        else if (s_tdata == CHAR_NL)
        begin
            q_op.kind = KIND_NL;
        end
        else if (s_tdata == CHAR_TAB)
        begin
            q_op.kind = KIND_TAB;
        end
        else if (s_tdata >= CHAR_SPACE && s_tdata <= CHAR_LAST)
        begin
            q_op.kind  = KIND_ADV;
            q_op.emit  = (s_tdata != CHAR_SPACE);
            q_op.adv   = advance_of(s_tdata);
            q_op.tex_s = glyph_tex_s(s_tdata);
        end
        else
        begin
            keep = 1'b0;
        end
    end

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && s_tready && keep;

endmodule

`default_nettype wire

/* hdl/tgl_fifo.sv */
// Short queue of classified characters between front and back end.
`default_nettype none

module tgl_fifo (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          wr_en,
    input  wire tgl_pkg::op_t  wr_data,
    output logic               full,
    input  wire logic          rd_en,
    output tgl_pkg::op_t       rd_data,
    output logic               empty
);
    import tgl_pkg::*;

    op_t                   entries [0:FIFO_DEPTH-1];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_CNT_W-1:0] count_reg;
    logic [FIFO_CNT_W-1:0] count_next;
    logic                  do_wr;
    logic                  do_rd;

    assign full    = (count_reg == FIFO_CNT_W'(FIFO_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = entries[rd_ptr_reg];

    // Track fill level
    always_comb
    begin
        count_next = count_reg;
        if (do_wr && !do_rd)
            count_next = count_reg + 1'b1;
        else if (do_rd && !do_wr)
            count_next = count_reg - 1'b1;
    end

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_rd)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    // Store the entry
    always_ff @(posedge clk)
    begin
        if (do_wr)
            entries[wr_ptr_reg] <= wr_data;
    end

    // Fill level stays within the depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("queue count beyond depth");

    // A lone write grows the queue by one
    a_write_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (do_wr && !do_rd) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue write did not grow count");

    // A lone read shrinks the queue by one
    a_read_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        (do_rd && !do_wr) |=> count_reg == $past(count_reg) - 1'b1)
        else $error("queue read did not shrink count");

endmodule

`default_nettype wire

/* hdl/tgl_back.sv */
// Back end: keeps the pen and origin, carries out queued characters, drives results.
`default_nettype none

module tgl_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cfg_we,
    input  wire logic          cfg_index,
    input  wire logic [11:0]   cfg_wdata,
    input  wire logic          head_valid,
    input  wire tgl_pkg::op_t  head,
    output logic               pop,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [79:0]        m_tdata
);
    import tgl_pkg::*;

    logic [PEN_W-1:0] origin_x_reg;
    logic [PEN_W-1:0] origin_y_reg;
    logic [PEN_W-1:0] pen_x_reg;
    logic [PEN_W-1:0] pen_x_next;
    logic [PEN_W-1:0] pen_y_reg;
    logic [PEN_W-1:0] pen_y_next;
    logic             out_valid_reg;
    logic [13:0]      rect_left_reg;
    logic [13:0]      rect_top_reg;
    logic [14:0]      rect_right_reg;
    logic [14:0]      rect_bottom_reg;
    logic [14:0]      tex_s_reg;

    logic             out_free;
    logic [12:0]      adv_sum;
    logic [12:0]      line_sum;
    logic signed [13:0] tab_t;
    logic signed [13:0] tab_adj;
    logic signed [14:0] tab_x;

    assign out_free = !out_valid_reg || m_tready;
    assign pop      = head_valid && (!head.emit || out_free);

    // Pen arithmetic for each kind of step
    always_comb
    begin
        adv_sum  = {1'b0, pen_x_reg} + 13'(head.adv);
        line_sum = {1'b0, pen_y_reg} + 13'(LINE_STEP);
        tab_t    = $signed({2'b00, pen_x_reg}) - $signed({2'b00, origin_x_reg})
                   + $signed(14'(TAB_STOP));
        // Stop count truncates toward zero, so round negatives up
        tab_adj  = tab_t[13] ? tab_t + 14'sd15 : tab_t;
        tab_x    = $signed({tab_adj[13], tab_adj[13:4], 4'b0000})
                   + $signed({3'b000, origin_x_reg});
    end

    // Next pen position
    always_comb
    begin
        pen_x_next = pen_x_reg;
        pen_y_next = pen_y_reg;
        if (pop)
        begin
            unique case (head.kind)
                KIND_NUL:
                begin
                    pen_x_next = origin_x_reg;
                    pen_y_next = origin_y_reg;
                end
                KIND_NL:
                begin
                    pen_x_next = origin_x_reg;
                    pen_y_next = line_sum[12] ? PEN_MAX : line_sum[11:0];
                end
                KIND_TAB:
                begin
                    if (tab_x[14])
                        pen_x_next = '0;
                    else if (tab_x[13:12] != 2'b00)
                        pen_x_next = PEN_MAX;
                    else
                        pen_x_next = tab_x[11:0];
                end
                KIND_ADV:
                begin
                    pen_x_next = adv_sum[12] ? PEN_MAX : adv_sum[11:0];
                end
                default:
                begin
                    pen_x_next = pen_x_reg;
                end
            endcase
        end
    end

    // Hold origin and pen, flag a waiting result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg  <= '0;
            origin_y_reg  <= '0;
            pen_x_reg     <= '0;
            pen_y_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we && cfg_index == REG_ORIGIN_X)
                origin_x_reg <= cfg_wdata;
            if (cfg_we && cfg_index == REG_ORIGIN_Y)
                origin_y_reg <= cfg_wdata;
            pen_x_reg <= pen_x_next;
            pen_y_reg <= pen_y_next;
            if (pop && head.emit)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Load the glyph rectangle at the current pen
    always_ff @(posedge clk)
    begin
        if (pop && head.emit)
        begin
            rect_left_reg   <= {pen_x_reg, 2'b00};
            rect_top_reg    <= {pen_y_reg, 2'b00};
            rect_right_reg  <= {{1'b0, pen_x_reg} + 13'(GLYPH_W), 2'b00};
            rect_bottom_reg <= {{1'b0, pen_y_reg} + 13'(LINE_STEP), 2'b00};
            tex_s_reg       <= head.tex_s;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, tex_s_reg, rect_bottom_reg, rect_right_reg,
                       rect_top_reg, rect_left_reg};

    // A drawn glyph shows up as a result beat
    a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && head.emit) |=> out_valid_reg)
        else $error("drawn glyph produced no result beat");

    // End of string puts the pen at the origin
    a_nul_origin: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && head.kind == KIND_NUL) |=>
            (pen_x_reg == $past(origin_x_reg) && pen_y_reg == $past(origin_y_reg)))
        else $error("pen not at origin after end of string");

    // Newline returns x and never moves y up
    a_nl_moves_down: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && head.kind == KIND_NL) |=>
            (pen_x_reg == $past(origin_x_reg) && pen_y_reg >= $past(pen_y_reg)))
        else $error("newline moved pen wrongly");

    // Advancing never moves the pen left or down
    a_adv_forward: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && head.kind == KIND_ADV) |=>
            (pen_x_reg >= $past(pen_x_reg) && pen_y_reg == $past(pen_y_reg)))
        else $error("advance moved pen backward");

    // Pen holds while nothing is taken from the queue
    a_pen_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !pop |=> ($stable(pen_x_reg) && $stable(pen_y_reg)))
        else $error("pen moved without a queued character");

endmodule

`default_nettype wire

/* hdl/text_glyph_layout.sv */
// Top level of the text glyph layout block: front end, queue and back end.
//
// Usage: character codes arrive one byte per beat on the s_ channel. Each
// printable non-space character yields one beat on the m_ channel with its
// glyph rectangle in quarter pixels and its font strip S coordinate. Space,
// tab, newline and NUL only move the pen; other codes are taken and dropped.
// origin_x (index 0) and origin_y (index 1) are written through cfg_we,
// cfg_index and cfg_wdata; the user must write them only while no character
// is in flight; the block leaves this unchecked. Throughput: one character
// per cycle while m_tready stays high. An accepted glyph is written into
// the queue, then popped by the back end into the result register, which
// drives m_tvalid. The pen update in the back end is one add and clamp.
// Stall: when the receiver holds m_tready low, the result register keeps its
// beat, the back end stops at the next glyph, and the four-entry queue fills;
// s_tready drops once it is full.
// Reset: pen and both origins clear to zero; queue and result register empty.
`default_nettype none

module text_glyph_layout (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cfg_we,
    input  wire logic          cfg_index,
    input  wire logic [11:0]   cfg_wdata,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [7:0]    s_tdata,   // [7:0] char_code
    output logic               m_tvalid,
    input  wire logic          m_tready,
    // [13:0] rect_left, [27:14] rect_top, [42:28] rect_right,
    // [57:43] rect_bottom, [72:58] tex_s, [79:73] zero
    output logic [79:0]        m_tdata
);
    import tgl_pkg::*;

    logic q_full;
    logic q_empty;
    logic q_push;
    logic q_pop;
    op_t  q_in;
    op_t  q_head;

    tgl_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_op     (q_in)
    );

    tgl_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (q_in),
        .full    (q_full),
        .rd_en   (q_pop),
        .rd_data (q_head),
        .empty   (q_empty)
    );

    tgl_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .head_valid (!q_empty),
        .head       (q_head),
        .pop        (q_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

`default_nettype wire

/* sim/tb.sv */
// Self-checking testbench for the text glyph layout block.
`timescale 1ns / 1ps

module tb;
    import tgl_pkg::*;

    localparam int LINE_PX       = 12;
    localparam int TAB_PX        = 16;
    localparam int GLYPH_W_PX    = 8;
    localparam int GLYPH_H_PX    = 12;
    localparam int PEN_TOP       = 4095;
    localparam int NUM_PHASES    = 6;
    localparam int RAND_PER_PH   = 240;
    localparam int STALL_PHASE   = 1;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 10;
    localparam int MAX_REPORTS   = 40;

    // Pen advance in pixels per code, space first
    localparam int ADV_PX [95] = '{
        2, 4, 5, 0, 0, 7, 7, 2, 5, 5, 0, 7, 3, 7, 3, 7,
        7, 7, 7, 7, 7, 7, 7, 7, 7, 7, 3, 3, 0, 0, 0, 7,
        0, 7, 7, 7, 7, 7, 7, 7, 7, 6, 7, 7, 7, 7, 7, 7,
        7, 7, 7, 7, 7, 7, 7, 7, 7, 7, 7, 0, 0, 0, 6, 0,
        0, 6, 6, 6, 6, 6, 6, 6, 6, 2, 6, 5, 3, 6, 6, 6,
        6, 6, 6, 6, 6, 6, 6, 6, 6, 6, 6, 0, 0, 0, 7
    };

    // Range ends of every strip gap, the j glyph, control codes, and
    // boundary codes that must be dropped
    localparam logic [7:0] DIRECTED [25] = '{
        "!", "~", "j", "i", "k", ";", "<", "?", "@", "Z", "[", "^", "_",
        "z", "{", CHAR_SPACE, CHAR_TAB, CHAR_NL,
        8'd1, 8'd8, 8'd11, 8'd31, 8'd127, 8'd255, CHAR_NUL
    };

    // Origin per phase; the last phases pick random origins
    localparam logic [11:0] PH_ORG_X [4] = '{12'd4095, 12'd100, 12'd3990, 12'd0};
    localparam logic [11:0] PH_ORG_Y [4] = '{12'd4095, 12'd4000, 12'd20, 12'd0};
    localparam int PH_READY_PCT [NUM_PHASES] = '{70, 50, 90, 100, 30, 60};

    typedef struct packed {
        logic [13:0] rect_left;
        logic [13:0] rect_top;
        logic [14:0] rect_right;
        logic [14:0] rect_bottom;
        logic [14:0] tex_s;
    } glyph_rect_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic        cfg_index = REG_ORIGIN_X;
    logic [11:0] cfg_wdata = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [79:0] m_tdata;

    // Layout state mirrored by the testbench
    logic [11:0] pen_x = '0;
    logic [11:0] pen_y = '0;
    logic [11:0] org_x = '0;
    logic [11:0] org_y = '0;

    logic [7:0]  char_q [$];
    glyph_rect_t rect_q [$];

    int  err_count   = 0;
    int  chars_sent  = 0;
    int  rects_seen  = 0;
    bit  idle_en     = 1'b0;
    int  ready_pct   = 100;
    int  stall_req   = 0;
    int  stall_ack   = 0;
    int  burst_left  = 0;
    int  gap_left    = 0;
    int  run_left    = 0;
    bit  run_level   = 1'b1;
    int  hold_left   = 0;

    text_glyph_layout u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("tb: FAIL");
        $finish;
    end

    function automatic logic [11:0] sat_pen(input int v);
        if (v < 0)
            return '0;
        if (v > PEN_TOP)
            return 12'(PEN_TOP);
        return 12'(v);
    endfunction

    function automatic bit is_ignored(input logic [7:0] code);
        if (code == CHAR_NUL || code == CHAR_NL || code == CHAR_TAB)
            return 1'b0;
        return (code < CHAR_SPACE) || (code > CHAR_LAST);
    endfunction

    // Strip S in U10.5: column over the gapped code ranges, times 8, plus
    // a one-unit nudge for the j glyph
    function automatic logic [14:0] strip_s(input logic [7:0] code);
        int col;
        col = int'(code) - int'(CHAR_FIRST);
        if (code > CHAR_LOWER_Z)
            col = col - int'(GAP_ABOVE_LOWER_Z);
        else if (code > CHAR_CARET)
            col = col - int'(GAP_ABOVE_CARET);
        else if (code > CHAR_UPPER_Z)
            col = col - int'(GAP_ABOVE_UPPER_Z);
        else if (code > CHAR_QUEST)
            col = col - int'(GAP_ABOVE_QUEST);
        else if (code > CHAR_SEMI)
            col = col - int'(GAP_ABOVE_SEMI);
        return 15'((col * 8) * 32 + ((col == int'(J_COL)) ? 1 : 0));
    endfunction

    // Apply one character to the pen and queue the rectangle it draws
    function automatic void layout_char(input logic [7:0] code);
        glyph_rect_t r;
        int d;
        int stops;
        if (code == CHAR_NUL)
        begin
            pen_x = org_x;
            pen_y = org_y;
        end
        else if (code == CHAR_NL)
        begin
            pen_x = org_x;
            pen_y = sat_pen(int'(pen_y) + LINE_PX);
        end
        else if (code == CHAR_TAB)
        begin
            // division truncates toward zero when the pen is left of origin
            d = int'(pen_x) - int'(org_x) + 1;
            stops = (d + TAB_PX - 1) / TAB_PX;
            pen_x = sat_pen(stops * TAB_PX + int'(org_x));
        end
        else if (!is_ignored(code))
        begin
            if (code != CHAR_SPACE)
            begin
                r.rect_left   = {pen_x, 2'b00};
                r.rect_top    = {pen_y, 2'b00};
                r.rect_right  = 15'((int'(pen_x) + GLYPH_W_PX) * 4);
                r.rect_bottom = 15'((int'(pen_y) + GLYPH_H_PX) * 4);
                r.tex_s       = strip_s(code);
                rect_q.push_back(r);
            end
            pen_x = sat_pen(int'(pen_x) + ADV_PX[code - CHAR_SPACE]);
        end
    endfunction

    function automatic void check_field(input string name, input int exp_v, input int got_v);
        if (exp_v != got_v)
        begin
            err_count++;
            if (err_count <= MAX_REPORTS)
                $display("[%0t] %s mismatch: expected %0d, actual %0d",
                         $time, name, exp_v, got_v);
        end
    endfunction

    // Drive characters in bursts; predict on every accepted beat
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            burst_left = 0;
            gap_left = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                layout_char(s_tdata);
                chars_sent++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end
                else if (char_q.size() != 0)
                begin
                    s_tvalid <= 1'b1;
                    s_tdata <= char_q.pop_front();
                    burst_left--;
                    if (idle_en && burst_left <= 0)
                    begin
                        gap_left = $urandom_range(1, 8);
                        burst_left = $urandom_range(1, 20);
                    end
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random ready runs, plus a long hold-off on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            run_left = 0;
            hold_left = 0;
        end
        else if (stall_ack != stall_req)
        begin
            stall_ack = stall_req;
            hold_left = HOLD_CYCLES;
            m_tready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
        begin
            if (run_left == 0)
            begin
                run_left = $urandom_range(1, 12);
                run_level = ($urandom_range(0, 99) < ready_pct);
            end
            run_left--;
            m_tready <= run_level;
        end
    end

    // Compare each glyph beat with the oldest expected rectangle
    always @(posedge clk)
    begin
        glyph_rect_t e;
        if (rst_n && m_tvalid && m_tready)
        begin
            rects_seen++;
            if (rect_q.size() == 0)
            begin
                err_count++;
                if (err_count <= MAX_REPORTS)
                    $display("[%0t] unexpected glyph beat: expected none, actual %h",
                             $time, m_tdata);
            end
            else
            begin
                e = rect_q.pop_front();
                check_field("rect_left", e.rect_left, m_tdata[13:0]);
                check_field("rect_top", e.rect_top, m_tdata[27:14]);
                check_field("rect_right", e.rect_right, m_tdata[42:28]);
                check_field("rect_bottom", e.rect_bottom, m_tdata[57:43]);
                check_field("tex_s", e.tex_s, m_tdata[72:58]);
            end
        end
    end

    task automatic write_reg(input logic idx, input logic [11:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_ORIGIN_X)
            org_x = val;
        else
            org_y = val;
    endtask

    // Hold until all characters are taken and every rectangle has come out,
    // then let trailing non-drawing characters clear the pipeline
    task automatic wait_idle();
        do
            @(negedge clk);
        while (char_q.size() != 0 || s_tvalid || rect_q.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Mostly printable text with line breaks, tabs and string ends; some noise
    task automatic fill_random(input int n);
        int taken;
        int r;
        logic [7:0] c;
        taken = 0;
        while (taken < n)
        begin
            r = $urandom_range(0, 99);
            if (r < 72)
                c = 8'($urandom_range(CHAR_FIRST, CHAR_LAST));
            else if (r < 80)
                c = CHAR_SPACE;
            else if (r < 86)
                c = CHAR_NL;
            else if (r < 90)
                c = CHAR_TAB;
            else if (r < 92)
                c = CHAR_NUL;
            else
                c = 8'($urandom_range(0, 255));
            char_q.push_back(c);
            if (!is_ignored(c))
                taken++;
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed characters at reset origin, no idling
        @(negedge clk);
        foreach (DIRECTED[i])
            char_q.push_back(DIRECTED[i]);
        wait_idle();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_reg(REG_ORIGIN_X, (p < 4) ? PH_ORG_X[p] : 12'($urandom));
            write_reg(REG_ORIGIN_Y, (p < 4) ? PH_ORG_Y[p] : 12'($urandom));
            @(negedge clk);
            idle_en = (p != 3);
            ready_pct = PH_READY_PCT[p];
            // the pen may sit left of the new origin here
            char_q.push_back(CHAR_TAB);
            fill_random(RAND_PER_PH);
            if (p == STALL_PHASE)
                stall_req++;
            wait_idle();
        end

        $display("tb: %0d characters sent, %0d glyph rectangles checked",
                 chars_sent, rects_seen);
        $display("tb: %0d origin settings incl. both extremes, one long output hold-off",
                 NUM_PHASES + 1);
        if (err_count == 0 && rect_q.size() == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
